FILE: design/afpt_pkg.sv
// Package with AES constants, types and round functions for the packet tag core.
`timescale 1ns / 1ps
package afpt_pkg;

  localparam int NumRounds = 10;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CUST_LO = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CUST_HI = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FACT_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FACT_HI = 2'd3;
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_OTP = 1'b1;

  typedef logic [127:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits in bits 8i+7:8i.
  function automatic blk_t round_fn(input blk_t s, input blk_t rk, input logic last);
    blk_t t;
    blk_t m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[32*c +: 8];
      a1 = t[32*c+8 +: 8];
      a2 = t[32*c+16 +: 8];
      a3 = t[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[32*c +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      m[32*c+8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    round_fn = (last ? t : m) ^ rk;
  endfunction

  function automatic blk_t key_next(input blk_t k, input logic [7:0] rc);
    blk_t n;
    logic [31:0] w;
    w = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    n[31:0] = k[31:0] ^ w;
    n[63:32] = k[63:32] ^ n[31:0];
    n[95:64] = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    key_next = n;
  endfunction

endpackage

FILE: design/aes_folded_packet_tag_core.sv
// Pipelined AES-128 tag core: one round and one key-schedule step per stage.
//
// Channel | Dir | tdata (low bit up)                                        | tuser
// in_     | in  | block_low, block_high, device_id, time_value (208 bits)   | opcode
// out_    | out | tag (32 bits)                                             | -
// cfg_    | in  | write enable, index 0..3, 64-bit key half                 | -
//
// One word enters every cycle unless a held output stalls the pipeline.
// Each of the ten AES rounds and its round-key step has its own pipeline stage.
// Reset clears the valid bits and the key registers to zero.
// A stall holds every stage in place, so nothing is lost or repeated.
`timescale 1ns / 1ps
module aes_folded_packet_tag_core import afpt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [207:0] in_tdata,   // block_low, block_high, device_id, time_value
  input  logic         in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // tag
  input  logic         cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] cust_lo_r, cust_hi_r, fact_lo_r, fact_hi_r;
  blk_t st_r [NumRounds+1];
  blk_t rk_r [NumRounds+1];
  logic [NumRounds:0] vld_r;
  logic [31:0] tag_r;
  logic out_vld_r;
  logic adv;
  blk_t pt, key0;
  logic [47:0] id;
  logic [31:0] tv;

  assign adv = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata = tag_r;
  assign id = in_tdata[175:128];
  assign tv = in_tdata[207:176];

  always_comb begin
    if (in_tuser == OP_OTP) begin
      key0 = {fact_hi_r, fact_lo_r};
      pt = {id, tv, id};
    end else begin
      key0 = {cust_hi_r, cust_lo_r};
      pt = in_tdata[127:0] ^ 128'h0f0e0d0c0b0a09080706050403020100;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cust_lo_r <= '0;
      cust_hi_r <= '0;
      fact_lo_r <= '0;
      fact_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUST_LO: cust_lo_r <= cfg_data;
        CFG_CUST_HI: cust_hi_r <= cfg_data;
        CFG_FACT_LO: fact_lo_r <= cfg_data;
        CFG_FACT_HI: fact_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[NumRounds-1:0], in_tvalid};
      out_vld_r <= vld_r[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= pt ^ key0;
      rk_r[0] <= key0;
      for (int i = 1; i <= NumRounds; i++) begin
        st_r[i] <= round_fn(st_r[i-1], key_next(rk_r[i-1], RCON[i-1]), i == NumRounds);
        rk_r[i] <= key_next(rk_r[i-1], RCON[i-1]);
      end
      for (int k = 0; k < 4; k++) begin
        tag_r[8*k +: 8] <= st_r[NumRounds][32*k +: 8] ^ st_r[NumRounds][32*k+8 +: 8]
                         ^ st_r[NumRounds][32*k+16 +: 8] ^ st_r[NumRounds][32*k+24 +: 8];
      end
    end
  end

endmodule

FILE: design/afpt_checker.sv
// Port-level checker for the packet tag core, bound to the top level.
`timescale 1ns / 1ps
module afpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled output word changed.");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("Input blocked with empty output.");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("Input taken while output stalled.");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind aes_folded_packet_tag_core afpt_checker u_afpt_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

FILE: dv/tb.sv
// Testbench for the AES-128 folded packet tag core: table plus random words, checked by a predictor.
`timescale 1ns / 1ps
module tb;
  import afpt_pkg::*;

  typedef struct {
    logic        op;
    logic [63:0] blo;
    logic [63:0] bhi;
    logic [47:0] id;
    logic [31:0] tv;
    logic        known;
    logic [31:0] tag;
  } word_row_t;

  localparam logic [7:0] SUB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  logic [63:0] cust_lo, cust_hi, fact_lo, fact_hi;
  logic [31:0] tag_fifo[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  bit          hold_off = 1'b0;
  bit          hold_seen = 1'b0;
  bit          stim_done = 1'b0;
  word_row_t   dir_rows[$];

  aes_folded_packet_tag_core dut (.*);

  always #4 clk = ~clk;

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] fold_tag(input word_row_t w);
    logic [7:0] kb [176];
    logic [7:0] st [16];
    logic [7:0] sb [16];
    logic [7:0] tw [4];
    logic [7:0] f, a0, a1, a2, a3, al;
    logic [7:0] rc;
    logic [127:0] key;
    logic [31:0] res;
    key = (w.op == OP_OTP) ? {fact_hi, fact_lo} : {cust_hi, cust_lo};
    for (int i = 0; i < 16; i++) begin
      kb[i] = key[8*i +: 8];
      if (w.op == OP_OTP) begin
        if (i < 6) st[i] = w.id[8*i +: 8];
        else if (i < 10) st[i] = w.tv[8*(i-6) +: 8];
        else st[i] = w.id[8*(i-10) +: 8];
      end else begin
        st[i] = ((i < 8) ? w.blo[8*i +: 8] : w.bhi[8*(i-8) +: 8]) ^ 8'(i);
      end
    end
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tw[j] = kb[4*(i-1)+j];
      if (i % 4 == 0) begin
        f = tw[0];
        tw[0] = SUB[tw[1]] ^ rc;
        tw[1] = SUB[tw[2]];
        tw[2] = SUB[tw[3]];
        tw[3] = SUB[f];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) kb[4*i+j] = kb[4*(i-4)+j] ^ tw[j];
    end
    for (int i = 0; i < 16; i++) st[i] ^= kb[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) sb[r+4*c] = SUB[st[r+4*((c+r)%4)]];
      for (int c = 0; c < 4; c++) begin
        a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (rnd == 10) begin
          for (int r = 0; r < 4; r++) st[4*c+r] = sb[4*c+r];
        end else begin
          st[4*c] = a0 ^ al ^ dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= kb[16*rnd+i];
    end
    for (int k = 0; k < 4; k++) res[8*k +: 8] = st[4*k] ^ st[4*k+1] ^ st[4*k+2] ^ st[4*k+3];
    return res;
  endfunction

  function automatic word_row_t rand_word();
    word_row_t w;
    w.op = logic'($urandom_range(0, 1));
    w.blo = {$urandom, $urandom};
    w.bhi = {$urandom, $urandom};
    w.id = {16'($urandom), $urandom};
    w.tv = $urandom;
    w.known = 1'b0;
    w.tag = '0;
    case ($urandom_range(0, 7))
      0: begin w.blo = '0; w.bhi = '0; w.id = '0; w.tv = '0; end
      1: begin w.blo = '1; w.bhi = '1; w.id = '1; w.tv = '1; end
      default: ;
    endcase
    return w;
  endfunction

  task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_CUST_LO: cust_lo = val;
      CFG_CUST_HI: cust_hi = val;
      CFG_FACT_LO: fact_lo = val;
      default: fact_hi = val;
    endcase
  endtask

  task automatic send_word(input word_row_t w);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= w.op;
    in_tdata <= {w.tv, w.id, w.bhi, w.blo};
    do @(posedge clk); while (!in_tready);
    tag_fifo.push_back(w.known ? w.tag : fold_tag(w));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tag_fifo.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic key_set(input logic [63:0] a, b, c, d);
    write_key(CFG_CUST_LO, a);
    write_key(CFG_CUST_HI, b);
    write_key(CFG_FACT_LO, c);
    write_key(CFG_FACT_HI, d);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tag_fifo.size() == 0) begin
        $error("unexpected word: tag actual %h", out_tdata);
        errors++;
      end else begin
        if (out_tdata !== tag_fifo[0]) begin
          $error("tag mismatch: expected %h actual %h", tag_fifo[0], out_tdata);
          errors++;
        end
        void'(tag_fifo.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 200;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 9) < 7) || stim_done;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    word_row_t w;
    cust_lo = '0; cust_hi = '0; fact_lo = '0; fact_hi = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed table under zero keys: an all-zero word, then mixed fields and both opcodes.
    w = '{OP_PACKET, 64'h0, 64'h0, 48'h0, 32'h0, 1'b0, 32'h0};
    for (int i = 0; i < 16; i++) begin
      dir_rows.push_back(w);
      w.op = ~w.op;
      w.blo = (i % 4 < 2) ? 64'h0 : '1;
      w.bhi = (i % 4 == 1) ? '1 : 64'h0706050403020100 ^ 64'h0f0e0d0c0b0a0908;
      w.id = (i % 3 == 0) ? '1 : 48'h0;
      w.tv = (i % 5 == 0) ? '1 : 32'h8000_0001;
    end
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    drain();
    key_set('1, '1, '1, '1);
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    drain();
    key_set(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, {$urandom, $urandom},
            {$urandom, $urandom});
    for (int n = 0; n < 600; n++) begin
      if (n == 150) begin
        drain();
        key_set({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
      end
      if (n == 300) hold_off = 1'b1;
      if (n == 450) begin
        drain();
        key_set({$urandom, $urandom}, {$urandom, $urandom}, '0, '1);
      end
      if (n >= 300 && n < 340) begin
        in_tvalid <= 1'b1;
        w = rand_word();
        in_tuser <= w.op;
        in_tdata <= {w.tv, w.id, w.bhi, w.blo};
        do @(posedge clk); while (!in_tready);
        tag_fifo.push_back(fold_tag(w));
      end else begin
        send_word(rand_word());
      end
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (tag_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
